// ===== rtl/core/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse sound channel package
// Item types, request codes, register indices, reset values and the duty
// pattern lookup shared by the channel modules.
// ----------------------------------------------------------------------------
package psc_pkg;

   typedef enum logic [2:0] {
      OP_WRITE    = 3'd0,
      OP_READ     = 3'd1,
      OP_ADVANCE  = 3'd2,
      OP_LENGTH   = 3'd3,
      OP_ENVELOPE = 3'd4,
      OP_RESET    = 3'd5
   } op_type;

   localparam logic [1:0] REG_DUTY_LENGTH = 2'd0;
   localparam logic [1:0] REG_ENVELOPE    = 2'd1;
   localparam logic [1:0] REG_PERIOD_LOW  = 2'd2;
   localparam logic [1:0] REG_PERIOD_HIGH = 2'd3;

   localparam logic [7:0] DUTY_LENGTH_RESET = 8'h3F;
   localparam logic [7:0] PERIOD_HIGH_RESET = 8'hBF;
   localparam logic [7:0] DAC_MASK          = 8'hF8;
   localparam logic [6:0] LENGTH_LIMIT      = 7'd64;
   localparam logic [3:0] VOLUME_MAX        = 4'd15;
   localparam logic [3:0] LEVEL_DAC_OFF     = 4'd7;
   localparam logic [3:0] LEVEL_CHANNEL_OFF = 4'd15;
   localparam logic [11:0] PERIOD_SPAN      = 12'd2048;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] cycle_count;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] sample_level;
      logic       channel_on;
      logic       dac_on;
   } rsp_item_type;

   // Bit n of each row is the wave level at duty position n.
   localparam logic [7:0] DUTY_WAVE [4] = '{
      8'b1000_0000,
      8'b1000_0001,
      8'b1110_0001,
      8'b0111_1110
   };

   function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] pos);
      logic [7:0] row;
      row = DUTY_WAVE[duty];
      return row[pos];
   endfunction

   function automatic logic [13:0] reload_value(input logic [2:0] per_high,
                                                input logic [7:0] per_low);
      logic [11:0] span;
      span = PERIOD_SPAN - {1'b0, per_high, per_low};
      return {span, 2'b00};
   endfunction

endpackage

// ===== rtl/core/psc_exec.sv =====
// ----------------------------------------------------------------------------
// Pulse sound channel execution unit
// Holds the channel registers and counters, applies one item per cycle while
// item_fire is high and forms the result item from the state after that item.
// ----------------------------------------------------------------------------
module psc_exec
   import psc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [7:0]  duty_length_ff, duty_length_in;
   logic [7:0]  envelope_ff, envelope_in;
   logic [7:0]  period_low_ff, period_low_in;
   logic [7:0]  period_high_ff, period_high_in;
   logic        channel_enabled_ff, channel_enabled_in;
   logic        dac_enabled_ff, dac_enabled_in;
   logic [6:0]  length_count_ff, length_count_in;
   logic [2:0]  env_period_ff, env_period_in;
   logic [2:0]  env_timer_ff, env_timer_in;
   logic        env_increase_ff, env_increase_in;
   logic [3:0]  volume_ff, volume_in;
   logic [13:0] freq_timer_ff, freq_timer_in;
   logic [2:0]  duty_pos_ff, duty_pos_in;
   logic [7:0]  read_data;

   always_comb begin
      duty_length_in     = duty_length_ff;
      envelope_in        = envelope_ff;
      period_low_in      = period_low_ff;
      period_high_in     = period_high_ff;
      channel_enabled_in = channel_enabled_ff;
      dac_enabled_in     = dac_enabled_ff;
      length_count_in    = length_count_ff;
      env_period_in      = env_period_ff;
      env_timer_in       = env_timer_ff;
      env_increase_in    = env_increase_ff;
      volume_in          = volume_ff;
      freq_timer_in      = freq_timer_ff;
      duty_pos_in        = duty_pos_ff;
      read_data          = 8'd0;
      case (op_type'(item.op))
         OP_WRITE: begin
            case (item.reg_index)
               REG_DUTY_LENGTH: duty_length_in = item.write_data;
               REG_ENVELOPE:    envelope_in = item.write_data;
               REG_PERIOD_LOW:  period_low_in = item.write_data;
               default: begin
                  period_high_in = item.write_data;
                  if (item.write_data[7]) begin
                     if ((envelope_ff & DAC_MASK) == 8'd0) begin
                        dac_enabled_in     = 1'b0;
                        channel_enabled_in = 1'b0;
                     end else begin
                        dac_enabled_in     = 1'b1;
                        channel_enabled_in = 1'b1;
                        length_count_in    = {1'b0, duty_length_ff[5:0]};
                        env_period_in      = envelope_ff[2:0];
                        env_timer_in       = envelope_ff[2:0];
                        env_increase_in    = envelope_ff[3];
                        volume_in          = envelope_ff[7:4];
                        freq_timer_in      = reload_value(item.write_data[2:0], period_low_ff);
                        duty_pos_in        = 3'd0;
                     end
                  end
               end
            endcase
         end
         OP_READ: begin
            case (item.reg_index)
               REG_DUTY_LENGTH: read_data = duty_length_ff;
               REG_ENVELOPE:    read_data = envelope_ff;
               REG_PERIOD_LOW:  read_data = period_low_ff;
               default:         read_data = period_high_ff;
            endcase
         end
         OP_ADVANCE: begin
            if (channel_enabled_ff) begin
               if ({6'd0, item.cycle_count} >= freq_timer_ff) begin
                  freq_timer_in = reload_value(period_high_ff[2:0], period_low_ff);
                  duty_pos_in   = duty_pos_ff + 3'd1;
               end else begin
                  freq_timer_in = freq_timer_ff - {6'd0, item.cycle_count};
               end
            end
         end
         OP_LENGTH: begin
            if (period_high_ff[6] && (length_count_ff < LENGTH_LIMIT)) begin
               length_count_in = length_count_ff + 7'd1;
               if (length_count_in == LENGTH_LIMIT) begin
                  channel_enabled_in = 1'b0;
               end
            end
         end
         OP_ENVELOPE: begin
            if (env_period_ff != 3'd0) begin
               if (env_timer_ff <= 3'd1) begin
                  env_timer_in = env_period_ff;
                  if (env_increase_ff) begin
                     if (volume_ff < VOLUME_MAX) begin
                        volume_in = volume_ff + 4'd1;
                     end
                  end else if (volume_ff != 4'd0) begin
                     volume_in = volume_ff - 4'd1;
                  end
               end else begin
                  env_timer_in = env_timer_ff - 3'd1;
               end
            end
         end
         OP_RESET: begin
            duty_length_in     = DUTY_LENGTH_RESET;
            envelope_in        = 8'd0;
            period_low_in      = 8'd0;
            period_high_in     = PERIOD_HIGH_RESET;
            channel_enabled_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.read_data  = read_data;
      result.channel_on = channel_enabled_in;
      result.dac_on     = dac_enabled_in;
      if (!dac_enabled_in) begin
         result.sample_level = LEVEL_DAC_OFF;
      end else if (!channel_enabled_in) begin
         result.sample_level = LEVEL_CHANNEL_OFF;
      end else if (duty_bit(duty_length_in[7:6], duty_pos_in)) begin
         result.sample_level = volume_in;
      end else begin
         result.sample_level = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_length_ff     <= DUTY_LENGTH_RESET;
         envelope_ff        <= 8'd0;
         period_low_ff      <= 8'd0;
         period_high_ff     <= PERIOD_HIGH_RESET;
         channel_enabled_ff <= 1'b0;
         dac_enabled_ff     <= 1'b0;
         length_count_ff    <= 7'd0;
         env_period_ff      <= 3'd0;
         env_timer_ff       <= 3'd0;
         env_increase_ff    <= 1'b0;
         volume_ff          <= 4'd0;
         freq_timer_ff      <= 14'd0;
         duty_pos_ff        <= 3'd0;
      end else if (item_fire) begin
         duty_length_ff     <= duty_length_in;
         envelope_ff        <= envelope_in;
         period_low_ff      <= period_low_in;
         period_high_ff     <= period_high_in;
         channel_enabled_ff <= channel_enabled_in;
         dac_enabled_ff     <= dac_enabled_in;
         length_count_ff    <= length_count_in;
         env_period_ff      <= env_period_in;
         env_timer_ff       <= env_timer_in;
         env_increase_ff    <= env_increase_in;
         volume_ff          <= volume_in;
         freq_timer_ff      <= freq_timer_in;
         duty_pos_ff        <= duty_pos_in;
      end
   end

   // The channel can only be running while the DAC is on.
   assert property (@(posedge clock) disable iff (reset)
      channel_enabled_ff |-> dac_enabled_ff)
      else $error("channel enabled with the DAC off");

   assert property (@(posedge clock) disable iff (reset)
      length_count_ff <= LENGTH_LIMIT)
      else $error("length counter beyond its limit");

   assert property (@(posedge clock) disable iff (reset)
      env_timer_ff <= env_period_ff)
      else $error("envelope timer above its period");

   // A timer advance leaves a disabled channel's timer alone.
   assert property (@(posedge clock) disable iff (reset)
      (item_fire && (item.op == OP_ADVANCE) && !channel_enabled_ff)
         |=> $stable(freq_timer_ff) && $stable(duty_pos_ff))
      else $error("timer moved while the channel was disabled");

endmodule

// ===== rtl/core/pulse_sound_channel.sv =====
// ----------------------------------------------------------------------------
// Pulse sound channel
// Square-wave channel with duty patterns, length counter and volume envelope.
// ----------------------------------------------------------------------------
// The channel takes one item per clock cycle while req_ready is high and
// returns one result item for each, in order. An accepted item sits in an
// input register until the output register can take its result, is applied
// to the channel state in a single pass, and its result is held in the
// output register, which offers it on rsp_valid. Both registers keep moving
// while the result side takes items; a stalled result holds one item in each
// register before req_ready falls.
module pulse_sound_channel
   import psc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_type,
   input  logic [1:0] req_reg_index,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_cycle_count,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [3:0] rsp_sample_level,
   output logic       rsp_channel_on,
   output logic       rsp_dac_on
);

   logic         item_valid_ff;
   req_item_type item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;
   rsp_item_type result;
   logic         move;
   logic         item_fire;

   assign move      = !rsp_valid_ff || rsp_ready;
   assign req_ready = !item_valid_ff || move;
   assign item_fire = item_valid_ff && move;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (move) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.op          <= req_type;
         item_ff.reg_index   <= req_reg_index;
         item_ff.write_data  <= req_write_data;
         item_ff.cycle_count <= req_cycle_count;
      end
      if (item_fire) begin
         rsp_ff <= result;
      end
   end

   psc_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item      (item_ff),
      .result    (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_sample_level = rsp_ff.sample_level;
   assign rsp_channel_on   = rsp_ff.channel_on;
   assign rsp_dac_on       = rsp_ff.dac_on;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.dac_on) |-> (rsp_ff.sample_level == LEVEL_DAC_OFF))
      else $error("result level wrong with the DAC off");

endmodule
